### rtl/core/kab_pkg.sv
`default_nettype none
package kab_pkg;
    localparam int FracCov = 24;
    localparam logic [31:0] AngleNoiseReset = 32'd7550;
    localparam logic [31:0] BiasNoiseReset  = 32'd1342;
    localparam logic [31:0] MeasNoiseReset  = 32'd503316;
    localparam logic [1:0] RegAngleNoise = 2'd0;
    localparam logic [1:0] RegBiasNoise  = 2'd1;
    localparam logic [1:0] RegMeasNoise  = 2'd2;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi) return 32'h7fffffff;
        else if (v < lo) return 32'h80000000;
        else return v[31:0];
    endfunction

    // round to nearest, ties toward plus infinity: add half then floor
    function automatic logic signed [65:0] rnd24(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v + 66'sd8388608;
        return t >>> FracCov;
    endfunction
endpackage
`default_nettype wire

### rtl/core/kalman_angle_bias_filter.sv
`default_nettype none
// Two-state angle/gyro-bias Kalman filter in fixed point (Q12.20 angles,
// Q8.24 covariance). One item at a time: one shared 33x33 multiplier runs
// ten sequenced products, and a radix-2 restoring divider forms each gain
// in a load step, 57 divide steps and a finish step. The block is ready
// again the cycle after the result is loaded; a previous result still
// waiting at the output holds the finished item back until it is taken.
// Register writes are taken only while no item is in work.
module kalman_angle_bias_filter
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [28:0] measured_angle, [60:29] gyro_rate, [89:61] time_step, [95:90] zero
    input  wire logic [95:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] angle_estimate
    output logic [31:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import kab_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_RATE, S_ANG, S_DP11, S_BRK, S_P00, S_P11, S_S,
        S_DIV0, S_DIV1, S_Y, S_MK0, S_MK1, S_C00, S_C01, S_C10, S_C11, S_OUT
    } state_t;

    state_t state_reg;
    logic [31:0] qa_reg, qb_reg, r_reg;
    logic signed [31:0] ang_reg, bias_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] meas_reg, gyro_reg, rate_reg, dp11_reg, k0_reg, k1_reg, y_reg;
    logic signed [31:0] p00t_reg, p01t_reg;
    logic [28:0] dt_reg;
    logic signed [34:0] s_reg;
    logic signed [32:0] ma, mb;
    logic signed [65:0] prod;
    logic signed [31:0] mq;
    logic [31:0] out_reg;
    logic out_valid_reg;

    // divider
    logic [63:0] dq_reg;      // quotient under construction
    logic [56:0] dnum_reg;    // dividend shift register (|numerator|*2^24 + d/2)
    logic [34:0] drem_reg;
    logic [33:0] dden_reg;
    logic dneg_reg;
    logic [5:0] dcnt_reg;
    logic [35:0] dtry;
    logic [64:0] qcap;
    logic signed [31:0] dres;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            S_ANG:  begin ma = {4'b0, dt_reg}; mb = {rate_reg[31], rate_reg}; end
            S_DP11: begin ma = {4'b0, dt_reg}; mb = {p11_reg[31], p11_reg}; end
            S_P00:  begin ma = {4'b0, dt_reg}; mb = {dp11_reg[31], dp11_reg}; end
            S_P11:  begin ma = {4'b0, dt_reg}; mb = {1'b0, qb_reg}; end
            S_MK0:  begin ma = {k0_reg[31], k0_reg}; mb = {y_reg[31], y_reg}; end
            S_MK1:  begin ma = {k1_reg[31], k1_reg}; mb = {y_reg[31], y_reg}; end
            S_C00:  begin ma = {k0_reg[31], k0_reg}; mb = {p00t_reg[31], p00t_reg}; end
            S_C01:  begin ma = {k0_reg[31], k0_reg}; mb = {p01t_reg[31], p01t_reg}; end
            S_C10:  begin ma = {k1_reg[31], k1_reg}; mb = {p00t_reg[31], p00t_reg}; end
            S_C11:  begin ma = {k1_reg[31], k1_reg}; mb = {p01t_reg[31], p01t_reg}; end
            default: begin ma = '0; mb = '0; end
        endcase
        prod = 66'(ma * mb);
        mq = sat32(rnd24(prod));
    end

    // restoring divide step; quotient of unsigned dividend by |S|
    always_comb
    begin
        dtry = {drem_reg, dnum_reg[56]} - {2'b0, dden_reg};
        qcap = (dq_reg > 64'h1_0000_0000) ? 65'h1_0000_0000 : {1'b0, dq_reg};
        dres = dneg_reg ? sat32(-$signed({1'b0, qcap})) : sat32($signed({1'b0, qcap}));
    end

    function automatic logic [56:0] div_num(input logic signed [31:0] n,
                                            input logic [33:0] d);
        logic [31:0] m;
        m = n[31] ? 32'(-n) : n;
        return {1'b0, m, 24'b0} + {24'b0, d[33:1]};
    endfunction

    logic [33:0] sabs;
    assign sabs = s_reg[34] ? 34'(-s_reg) : s_reg[33:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            qa_reg <= AngleNoiseReset;
            qb_reg <= BiasNoiseReset;
            r_reg  <= MeasNoiseReset;
            ang_reg <= '0; bias_reg <= '0;
            p00_reg <= '0; p01_reg <= '0; p10_reg <= '0; p11_reg <= '0;
            out_valid_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    RegAngleNoise: qa_reg <= cfg_data;
                    RegBiasNoise:  qb_reg <= cfg_data;
                    RegMeasNoise:  r_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && m_tready && (state_reg != S_OUT)) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (s_tvalid && s_tready)
                    begin
                        meas_reg <= 32'(signed'(s_tdata[28:0]));
                        gyro_reg <= s_tdata[60:29];
                        dt_reg   <= s_tdata[89:61];
                        state_reg <= S_RATE;
                    end
                S_RATE: begin rate_reg <= sat32(66'(gyro_reg) - 66'(bias_reg));
                    state_reg <= S_ANG; end
                S_ANG: begin ang_reg <= sat32(66'(ang_reg) + rnd24(prod));
                    state_reg <= S_DP11; end
                S_DP11: begin dp11_reg <= mq; state_reg <= S_BRK; end
                S_BRK: begin
                    dp11_reg <= sat32(66'(dp11_reg) - 66'(p01_reg) - 66'(p10_reg)
                                      + $signed({34'b0, qa_reg}));
                    p01_reg <= sat32(66'(p01_reg) - 66'(dp11_reg));
                    p10_reg <= sat32(66'(p10_reg) - 66'(dp11_reg));
                    state_reg <= S_P00; end
                S_P00: begin p00_reg <= sat32(66'(p00_reg) + 66'(mq)); state_reg <= S_P11; end
                S_P11: begin p11_reg <= sat32(66'(p11_reg) + 66'(mq)); state_reg <= S_S; end
                S_S: begin s_reg <= 35'(p00_reg) + $signed({3'b0, r_reg});
                    state_reg <= S_DIV0; dcnt_reg <= '0; end
                S_DIV0, S_DIV1:
                begin
                    if (dcnt_reg == 6'd0)
                    begin
                        // load the dividend for this gain
                        dnum_reg <= div_num((state_reg == S_DIV0) ? p00_reg : p10_reg, sabs);
                        dneg_reg <= (((state_reg == S_DIV0) ? p00_reg[31] : p10_reg[31])
                                     ^ s_reg[34]);
                        dden_reg <= sabs; drem_reg <= '0; dq_reg <= '0;
                        dcnt_reg <= 6'd1;
                    end
                    else if (dcnt_reg <= 6'd57)
                    begin
                        if (!dtry[35])
                        begin
                            drem_reg <= dtry[34:0];
                            dq_reg <= {dq_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= {drem_reg[33:0], dnum_reg[56]};
                            dq_reg <= {dq_reg[62:0], 1'b0};
                        end
                        dnum_reg <= {dnum_reg[55:0], 1'b0};
                        dcnt_reg <= dcnt_reg + 6'd1;
                    end
                    else
                    begin
                        dcnt_reg <= '0;
                        if (state_reg == S_DIV0)
                        begin
                            k0_reg <= (s_reg == '0) ? '0 : dres;
                            state_reg <= S_DIV1;
                        end
                        else
                        begin
                            k1_reg <= (s_reg == '0) ? '0 : dres;
                            state_reg <= S_Y;
                        end
                    end
                end
                S_Y: begin y_reg <= sat32(66'(meas_reg) - 66'(ang_reg));
                    p00t_reg <= p00_reg; p01t_reg <= p01_reg; state_reg <= S_MK0; end
                S_MK0: begin ang_reg <= sat32(66'(ang_reg) + 66'(mq)); state_reg <= S_MK1; end
                S_MK1: begin bias_reg <= sat32(66'(bias_reg) + 66'(mq)); state_reg <= S_C00; end
                S_C00: begin p00_reg <= sat32(66'(p00_reg) - 66'(mq)); state_reg <= S_C01; end
                S_C01: begin p01_reg <= sat32(66'(p01_reg) - 66'(mq)); state_reg <= S_C10; end
                S_C10: begin p10_reg <= sat32(66'(p10_reg) - 66'(mq)); state_reg <= S_C11; end
                S_C11: begin p11_reg <= sat32(66'(p11_reg) - 66'(mq)); state_reg <= S_OUT; end
                S_OUT:
                    // hold until the output register is free
                    if (!out_valid_reg || m_tready)
                    begin
                        out_reg <= ang_reg;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped");
    a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> m_tvalid) else $error("result missing");
`endif
endmodule
`default_nettype wire
